// ===== rtl/core/rgse_pkg.sv =====
// Package for the RGB-to-gray Sobel edge unit.
// Sizes, gray weights, clamp limit and the pipeline tag type; no dependencies.
package rgse_pkg;

  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned PIXEL_BITS = 12;
  localparam int unsigned CFG_BITS   = 12;
  localparam int unsigned LINE_DEPTH = MAX_WIDTH + 2;
  localparam int unsigned ADDR_BITS  = $clog2(LINE_DEPTH);
  localparam int unsigned PROD_BITS  = PIXEL_BITS + 12;
  localparam int unsigned GRAD_BITS  = PIXEL_BITS + 4;

  localparam logic [11:0] W_RED   = 12'd1225;
  localparam logic [11:0] W_GREEN = 12'd2404;
  localparam logic [11:0] W_BLUE  = 12'd467;

  localparam logic [PIXEL_BITS-1:0] PIX_ONE = PIXEL_BITS'(1) << (PIXEL_BITS - 1);

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(1920);
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(1080);
  localparam logic [CFG_BITS-1:0] SIZE_MAX     = CFG_BITS'(MAX_WIDTH);

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic emit;
    logic eor;
    logic eof;
  } rgse_tag_t;

endpackage

// ===== rtl/core/rgb_to_gray_sobel_edge_unit.sv =====
// Top level of the RGB-to-gray Sobel edge unit: config regs, raster counters,
// pipeline control and output skid. Depends on rgse_pkg and the rgse_* modules.
//
//   channel  direction  handshake              payload
//   in       in         in_valid_i/in_ready_o  red_i, green_i, blue_i
//   out      out        out_valid_o/out_ready_i edge_strength_o, end_of_row_o, end_of_frame_o
//   cfg      in         APB psel/penable/pready active_width, active_height
//
// One item per cycle while the skid is empty; a result passes stages s1, s2, s3 and the output register.
// Line memory is read at accept and written back from the stage s1 address (single port pair).
// Output register plus one skid entry: input stalls only when the skid is full.
// Reset clears counters, window and valids; line memories need no clearing.
module rgb_to_gray_sobel_edge_unit import rgse_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIXEL_BITS-1:0] red_i,
  input  logic [PIXEL_BITS-1:0] green_i,
  input  logic [PIXEL_BITS-1:0] blue_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIXEL_BITS-1:0] edge_strength_o,
  output logic                  end_of_row_o,
  output logic                  end_of_frame_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [CFG_BITS-1:0] width_q, height_q, size_fit;
  logic [11:0] col_q, col_d, row_q, row_d;
  logic last_col, last_row, acc, en, cfg_wr;
  logic [ADDR_BITS-1:0] rd_addr, s1_addr_q;
  logic s1_vld_q, s2_vld_q, s3_vld_q, res_vld, out_take;
  rgse_tag_t s1_tag_q, s2_tag_q, s3_tag_q;
  logic [PIXEL_BITS-1:0] gray, top, mid, edge_val;
  logic out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  logic [PIXEL_BITS+1:0] out_q, out_d, skid_q, skid_d;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(height_q) : 32'(width_q);

  always_comb begin
    size_fit = pwdata[CFG_BITS-1:0];
    if (size_fit == '0) begin
      size_fit = CFG_BITS'(1);
    end else if (size_fit > SIZE_MAX) begin
      size_fit = SIZE_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_HEIGHT) begin
        height_q <= size_fit;
      end else begin
        width_q <= size_fit;
      end
    end
  end

  // raster position
  assign en         = ~skid_vld_q;
  assign in_ready_o = en;
  assign acc        = in_valid_i & en;
  assign last_col   = {1'b0, col_q} >= ({1'b0, width_q} + 13'd1);
  assign last_row   = {1'b0, row_q} >= ({1'b0, height_q} + 13'd1);
  assign rd_addr    = ({1'b0, col_q} < 13'(LINE_DEPTH)) ? ADDR_BITS'(col_q)
                                                         : ADDR_BITS'(LINE_DEPTH - 1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 12'd1;
      end else begin
        col_d = col_q + 12'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (en) begin
        s1_vld_q <= acc;
        s2_vld_q <= s1_vld_q & s1_tag_q.emit;
        s3_vld_q <= s2_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_addr_q     <= rd_addr;
      s1_tag_q.emit <= (col_q >= 12'd2) && (row_q >= 12'd2);
      s1_tag_q.eor  <= last_col;
      s1_tag_q.eof  <= last_col & last_row;
      s2_tag_q      <= s1_tag_q;
      s3_tag_q      <= s2_tag_q;
    end
  end

  rgse_gray u_gray (
    .clk_i   (clk_i),
    .en_i    (en),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .gray_o  (gray)
  );

  rgse_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (acc),
    .rd_addr_i (rd_addr),
    .wr_en_i   (en & s1_vld_q),
    .wr_addr_i (s1_addr_q),
    .wr_gray_i (gray),
    .top_o     (top),
    .mid_o     (mid)
  );

  rgse_sobel u_sobel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (en & s1_vld_q),
    .load_i  (en & s2_vld_q),
    .top_i   (top),
    .mid_i   (mid),
    .bot_i   (gray),
    .edge_o  (edge_val)
  );

  // output register and skid
  assign res_vld  = en & s3_vld_q;
  assign out_take = out_vld_q & out_ready_i;

  always_comb begin
    out_vld_d  = out_vld_q & ~out_take;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (skid_vld_q && (!out_vld_q || out_take)) begin
      out_d      = skid_q;
      out_vld_d  = 1'b1;
      skid_vld_d = 1'b0;
    end else if (res_vld) begin
      if (!out_vld_q || out_take) begin
        out_d     = {edge_val, s3_tag_q.eor, s3_tag_q.eof};
        out_vld_d = 1'b1;
      end else begin
        skid_d     = {edge_val, s3_tag_q.eor, s3_tag_q.eof};
        skid_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o     = out_vld_q;
  assign edge_strength_o = out_q[PIXEL_BITS+1:2];
  assign end_of_row_o    = out_q[1];
  assign end_of_frame_o  = out_q[0];

endmodule

// ===== rtl/core/rgse_gray.sv =====
// Gray conversion: registered weighted channel products, combinational sum.
// Depends on rgse_pkg.
module rgse_gray import rgse_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [PIXEL_BITS-1:0] red_i,
  input  logic [PIXEL_BITS-1:0] green_i,
  input  logic [PIXEL_BITS-1:0] blue_i,
  output logic [PIXEL_BITS-1:0] gray_o
);

  logic [PROD_BITS-1:0] pr_q, pg_q, pb_q;
  logic [PROD_BITS-1:0] sum;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q <= PROD_BITS'(W_RED) * PROD_BITS'(red_i);
      pg_q <= PROD_BITS'(W_GREEN) * PROD_BITS'(green_i);
      pb_q <= PROD_BITS'(W_BLUE) * PROD_BITS'(blue_i);
    end
  end

  assign sum    = pr_q + pg_q + pb_q;
  assign gray_o = sum[PROD_BITS-1:12];

endmodule

// ===== rtl/core/rgse_line_buf.sv =====
// Two gray line memories with registered reads; line one shifts into line two
// on write. Depends on rgse_pkg.
module rgse_line_buf import rgse_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rd_en_i,
  input  logic [ADDR_BITS-1:0]  rd_addr_i,
  input  logic                  wr_en_i,
  input  logic [ADDR_BITS-1:0]  wr_addr_i,
  input  logic [PIXEL_BITS-1:0] wr_gray_i,
  output logic [PIXEL_BITS-1:0] top_o,
  output logic [PIXEL_BITS-1:0] mid_o
);

  logic [PIXEL_BITS-1:0] mem_one [LINE_DEPTH];
  logic [PIXEL_BITS-1:0] mem_two [LINE_DEPTH];
  logic [PIXEL_BITS-1:0] rd_one_q, rd_two_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_one_q <= mem_one[rd_addr_i];
      rd_two_q <= mem_two[rd_addr_i];
    end
    if (wr_en_i) begin
      mem_one[wr_addr_i] <= wr_gray_i;
      mem_two[wr_addr_i] <= rd_one_q;
    end
  end

  assign top_o = rd_two_q;
  assign mid_o = rd_one_q;

endmodule

// ===== rtl/core/rgse_sobel.sv =====
// 3x3 gray window, registered Sobel sums and clamped L1 magnitude.
// Depends on rgse_pkg.
module rgse_sobel import rgse_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  logic                  load_i,
  input  logic [PIXEL_BITS-1:0] top_i,
  input  logic [PIXEL_BITS-1:0] mid_i,
  input  logic [PIXEL_BITS-1:0] bot_i,
  output logic [PIXEL_BITS-1:0] edge_o
);

  logic [PIXEL_BITS-1:0] win_q [3][3];
  logic signed [GRAD_BITS-1:0] gx_q, gy_q;
  logic signed [GRAD_BITS-1:0] gx_d, gy_d;
  logic [GRAD_BITS-1:0] ax, ay, mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (shift_i) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= top_i;
      win_q[1][2] <= mid_i;
      win_q[2][2] <= bot_i;
    end
  end

  always_comb begin
    gx_d = (GRAD_BITS'(win_q[0][2]) + (GRAD_BITS'(win_q[1][2]) << 1) + GRAD_BITS'(win_q[2][2]))
         - (GRAD_BITS'(win_q[0][0]) + (GRAD_BITS'(win_q[1][0]) << 1) + GRAD_BITS'(win_q[2][0]));
    gy_d = (GRAD_BITS'(win_q[2][0]) + (GRAD_BITS'(win_q[2][1]) << 1) + GRAD_BITS'(win_q[2][2]))
         - (GRAD_BITS'(win_q[0][0]) + (GRAD_BITS'(win_q[0][1]) << 1) + GRAD_BITS'(win_q[0][2]));
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
    end
  end

  always_comb begin
    ax  = gx_q[GRAD_BITS-1] ? GRAD_BITS'(-gx_q) : GRAD_BITS'(gx_q);
    ay  = gy_q[GRAD_BITS-1] ? GRAD_BITS'(-gy_q) : GRAD_BITS'(gy_q);
    mag = ax + ay;
    edge_o = (mag > GRAD_BITS'(PIX_ONE)) ? PIX_ONE : mag[PIXEL_BITS-1:0];
  end

endmodule
